// ===== hdl/ffac_pkg.sv =====
// ----------------------------------------------------------------------------
// ffac_pkg
// Shared types and constants of the first-fit allocator with compaction.
// ----------------------------------------------------------------------------
package ffac_pkg;

    // Default sizes of the managed byte map and of the block number space.
    localparam int MEM_BYTES_DEF = 128;
    localparam int ID_LIMIT_DEF  = 256;

    // Fixed field widths of the request, result and configuration channels.
    localparam int ACTION_W = 2;
    localparam int REQ_W    = 8;
    localparam int ERASE_W  = 16;
    localparam int BLOCK_W  = 8;
    localparam int CFG_W    = 8;

    localparam logic [CFG_W-1:0] MEM_SIZE_RESET = 8'd128;

    // Request codes. Any code that is neither alloc nor erase compacts the map.
    typedef logic [ACTION_W-1:0] action_t;
    localparam action_t ACT_ALLOC  = 2'd0;
    localparam action_t ACT_ERASE  = 2'd1;
    localparam action_t ACT_DEFRAG = 2'd2;

    typedef enum logic [1:0] {
        STAT_ALLOCATED = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_ILLEGAL   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_START,
        ST_ALLOC_SCAN,
        ST_ALLOC_FILL,
        ST_ERASE_START,
        ST_ERASE_CHECK,
        ST_ERASE_SCAN,
        ST_DEFRAG_MOVE,
        ST_DEFRAG_FILL,
        ST_RESULT
    } ffac_state_t;

    typedef struct packed {
        action_t                    action;
        logic [REQ_W-1:0]           request_size;
        logic signed [ERASE_W-1:0]  erase_id;
    } ffac_req_t;

    typedef struct packed {
        status_t              status;
        logic [BLOCK_W-1:0]   block_number;
    } ffac_res_t;

endpackage

// ===== hdl/ffac_core.sv =====
// ----------------------------------------------------------------------------
// ffac_core
// Sequencer and memories of the allocator: owner map and live flags, each a
// synchronous memory; the owner map is scanned one entry per cycle.
// ----------------------------------------------------------------------------
module ffac_core
    import ffac_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    parameter int ID_LIMIT  = ID_LIMIT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] memory_size,
    input  logic             req_valid,
    output logic             req_ready,
    input  ffac_req_t        req,
    output logic             res_valid,
    input  logic             res_ready,
    output ffac_res_t        res
);

    localparam int AW    = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int CW    = $clog2(MEM_BYTES + 1);
    localparam int IW    = $clog2(ID_LIMIT);
    localparam int SW    = ((CW > REQ_W) ? CW : REQ_W) + 1;
    localparam int CLR_N = (MEM_BYTES > ID_LIMIT) ? MEM_BYTES : ID_LIMIT;
    localparam int CLR_W = $clog2(CLR_N);

    // Memories.
    logic [IW-1:0] owner_mem [MEM_BYTES];
    logic          live_mem  [ID_LIMIT];

    logic          owner_we;
    logic [AW-1:0] owner_waddr;
    logic [IW-1:0] owner_wdata;
    logic          owner_re;
    logic [AW-1:0] owner_raddr;
    logic [IW-1:0] owner_rd_reg;

    logic          live_we;
    logic [IW-1:0] live_waddr;
    logic          live_wdata;
    logic          live_re;
    logic [IW-1:0] live_raddr;
    logic          live_rd_reg;

    // Control and working registers.
    ffac_state_t      state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [CW-1:0]    rd_reg, rd_next;
    logic             rvld_reg;
    logic [CW-1:0]    rpos_reg;
    logic [REQ_W-1:0] run_reg, run_next;
    logic [REQ_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]    wr_reg, wr_next;
    logic [IW-1:0]    last_reg, last_next;
    ffac_req_t        req_reg, req_next;
    ffac_res_t        res_reg, res_next;

    // Shared decision terms.
    logic [CW-1:0]  size_lim;
    logic [CW-1:0]  scan_lim;
    logic           scan_state;
    logic           scan_re;
    logic           scan_end;
    logic [REQ_W:0] run_inc;
    logic           alloc_hit;
    logic [SW-1:0]  start_calc;
    logic           exhausted;
    logic           erase_in_range;
    logic [IW-1:0]  erase_idx;
    logic [IW-1:0]  new_id;

    always_comb
    begin
        if (int'(memory_size) > MEM_BYTES)
        begin
            size_lim = CW'(MEM_BYTES);
        end
        else
        begin
            size_lim = CW'(memory_size);
        end
    end

    assign scan_state = state_reg inside {ST_ALLOC_SCAN, ST_ERASE_SCAN, ST_DEFRAG_MOVE};
    assign scan_lim   = (state_reg == ST_ALLOC_SCAN) ? size_lim : CW'(MEM_BYTES);
    assign scan_re    = scan_state && (rd_reg < scan_lim);
    assign scan_end   = !scan_re && !rvld_reg;
    assign run_inc    = {1'b0, run_reg} + (REQ_W + 1)'(1);
    assign alloc_hit  = (state_reg == ST_ALLOC_SCAN) && rvld_reg && (owner_rd_reg == '0)
                        && (run_inc == {1'b0, req_reg.request_size});
    assign start_calc = SW'(rpos_reg) + SW'(1) - SW'(req_reg.request_size);
    assign exhausted  = (last_reg == IW'(ID_LIMIT - 1));
    assign new_id     = last_reg + IW'(1);
    assign erase_in_range = (int'(req_reg.erase_id) > 0) && (int'(req_reg.erase_id) < ID_LIMIT);
    assign erase_idx  = req_reg.erase_id[IW-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CLR_W'(CLR_N - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.action)
                        ACT_ALLOC: state_next = ST_ALLOC_START;
                        ACT_ERASE: state_next = ST_ERASE_START;
                        default:   state_next = ST_DEFRAG_MOVE;
                    endcase
                end
            end
            ST_ALLOC_START:
            begin
                if (exhausted || (req_reg.request_size == '0))
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_ALLOC_SCAN;
                end
            end
            ST_ALLOC_SCAN:
            begin
                if (alloc_hit)
                begin
                    state_next = ST_ALLOC_FILL;
                end
                else if (scan_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_ALLOC_FILL:
            begin
                if (cnt_reg == REQ_W'(1))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_ERASE_START:
            begin
                state_next = erase_in_range ? ST_ERASE_CHECK : ST_RESULT;
            end
            ST_ERASE_CHECK:
            begin
                state_next = live_rd_reg ? ST_ERASE_SCAN : ST_RESULT;
            end
            ST_ERASE_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEFRAG_MOVE:
            begin
                if (scan_end)
                begin
                    state_next = ST_DEFRAG_FILL;
                end
            end
            ST_DEFRAG_FILL:
            begin
                if (wr_reg == CW'(MEM_BYTES))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs, memory controls and working registers.
    always_comb
    begin
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        owner_we    = 1'b0;
        owner_waddr = wr_reg[AW-1:0];
        owner_wdata = '0;
        owner_re    = 1'b0;
        owner_raddr = rd_reg[AW-1:0];
        live_we     = 1'b0;
        live_waddr  = new_id;
        live_wdata  = 1'b0;
        live_re     = 1'b0;
        live_raddr  = erase_idx;
        clr_next    = clr_reg;
        rd_next     = rd_reg;
        run_next    = run_reg;
        cnt_next    = cnt_reg;
        wr_next     = wr_reg;
        last_next   = last_reg;
        req_next    = req_reg;
        res_next    = res_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                owner_we    = int'(clr_reg) < MEM_BYTES;
                owner_waddr = clr_reg[AW-1:0];
                live_we     = int'(clr_reg) < ID_LIMIT;
                live_waddr  = clr_reg[IW-1:0];
                clr_next    = clr_reg + CLR_W'(1);
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next = req;
                    rd_next  = '0;
                    run_next = '0;
                    wr_next  = '0;
                end
            end
            ST_ALLOC_START:
            begin
                if (exhausted)
                begin
                    res_next.status       = STAT_NO_SPACE;
                    res_next.block_number = '0;
                end
                else if (req_reg.request_size == '0)
                begin
                    // An empty request takes a number that owns no bytes.
                    live_we               = 1'b1;
                    live_wdata            = 1'b1;
                    last_next             = new_id;
                    res_next.status       = STAT_ALLOCATED;
                    res_next.block_number = BLOCK_W'(new_id);
                end
            end
            ST_ALLOC_SCAN:
            begin
                owner_re = scan_re;
                if (scan_re)
                begin
                    rd_next = rd_reg + CW'(1);
                end
                if (rvld_reg)
                begin
                    run_next = (owner_rd_reg == '0) ? run_inc[REQ_W-1:0] : '0;
                end
                if (alloc_hit)
                begin
                    wr_next  = CW'(start_calc);
                    cnt_next = req_reg.request_size;
                end
                else if (scan_end)
                begin
                    res_next.status       = STAT_NO_SPACE;
                    res_next.block_number = '0;
                end
            end
            ST_ALLOC_FILL:
            begin
                owner_we    = 1'b1;
                owner_wdata = new_id;
                wr_next     = wr_reg + CW'(1);
                cnt_next    = cnt_reg - REQ_W'(1);
                if (cnt_reg == REQ_W'(1))
                begin
                    live_we               = 1'b1;
                    live_wdata            = 1'b1;
                    last_next             = new_id;
                    res_next.status       = STAT_ALLOCATED;
                    res_next.block_number = BLOCK_W'(new_id);
                end
            end
            ST_ERASE_START:
            begin
                if (erase_in_range)
                begin
                    live_re = 1'b1;
                end
                else
                begin
                    res_next.status       = STAT_ILLEGAL;
                    res_next.block_number = '0;
                end
            end
            ST_ERASE_CHECK:
            begin
                if (live_rd_reg)
                begin
                    live_we    = 1'b1;
                    live_waddr = erase_idx;
                end
                else
                begin
                    res_next.status       = STAT_ILLEGAL;
                    res_next.block_number = '0;
                end
            end
            ST_ERASE_SCAN:
            begin
                owner_re = scan_re;
                if (scan_re)
                begin
                    rd_next = rd_reg + CW'(1);
                end
                if (rvld_reg && (owner_rd_reg == erase_idx))
                begin
                    owner_we    = 1'b1;
                    owner_waddr = rpos_reg[AW-1:0];
                end
            end
            ST_DEFRAG_MOVE:
            begin
                owner_re = scan_re;
                if (scan_re)
                begin
                    rd_next = rd_reg + CW'(1);
                end
                // The write pointer never passes the read pointer, so a move
                // only lands on an entry that was already read.
                if (rvld_reg && (owner_rd_reg != '0))
                begin
                    owner_we    = 1'b1;
                    owner_wdata = owner_rd_reg;
                    wr_next     = wr_reg + CW'(1);
                end
            end
            ST_DEFRAG_FILL:
            begin
                if (wr_reg != CW'(MEM_BYTES))
                begin
                    owner_we = 1'b1;
                    wr_next  = wr_reg + CW'(1);
                end
            end
            ST_RESULT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            rd_reg    <= '0;
            rvld_reg  <= 1'b0;
            run_reg   <= '0;
            cnt_reg   <= '0;
            wr_reg    <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rd_reg    <= rd_next;
            rvld_reg  <= owner_re;
            run_reg   <= run_next;
            cnt_reg   <= cnt_next;
            wr_reg    <= wr_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rpos_reg <= rd_reg;
        req_reg  <= req_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_mem[owner_waddr] <= owner_wdata;
        end
        if (owner_re)
        begin
            owner_rd_reg <= owner_mem[owner_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[live_waddr] <= live_wdata;
        end
        if (live_re)
        begin
            live_rd_reg <= live_mem[live_raddr];
        end
    end

endmodule

// ===== hdl/first_fit_allocator_with_compaction_unit.sv =====
// Alloc: the owner map is read up to the fit, then the block's bytes are written; with no
//   fit the read stops at the clamped size, and an empty request or exhausted numbers skip it.
// Erase reads the whole map (not when illegal); defragment reads it, moving owned bytes down,
//   then clears the tail. One request is in work at a time; the owner map read port reads one
//   byte a cycle.
// Reset: a clearing pass empties both memories; requests wait.
// ----------------------------------------------------------------------------
// first_fit_allocator_with_compaction_unit
// First-fit byte allocator with erase and compaction, top level with the
// request, result and configuration ports.
// ----------------------------------------------------------------------------
module first_fit_allocator_with_compaction_unit
    import ffac_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    parameter int ID_LIMIT  = ID_LIMIT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // Configuration: the number of managed bytes.
    input  logic                      cfg_write_en,
    input  logic [CFG_W-1:0]          cfg_write_data,

    // Request channel.
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ACTION_W-1:0]       action,
    input  logic [REQ_W-1:0]          request_size,
    input  logic signed [ERASE_W-1:0] erase_id,

    // Result channel.
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                status,
    output logic [BLOCK_W-1:0]        block_number
);

    // The memory size register. Values above MEM_BYTES are clamped inside the
    // core, so the register simply holds what was written.
    logic [CFG_W-1:0] memory_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_size_reg <= MEM_SIZE_RESET;
        end
        else if (cfg_write_en)
        begin
            memory_size_reg <= cfg_write_data;
        end
    end

    // Request fields are gathered into one struct for the core. The core
    // captures them at the transfer, so the ports need not hold afterward.
    ffac_req_t req;
    ffac_res_t core_res;
    logic      core_res_valid;
    logic      core_res_ready;

    assign req.action       = action;
    assign req.request_size = request_size;
    assign req.erase_id     = erase_id;

    ffac_core #(
        .MEM_BYTES (MEM_BYTES),
        .ID_LIMIT  (ID_LIMIT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .memory_size (memory_size_reg),
        .req_valid   (in_valid),
        .req_ready   (in_ready),
        .req         (req),
        .res_valid   (core_res_valid),
        .res_ready   (core_res_ready),
        .res         (core_res)
    );

    // Output register. It decouples the result channel from the core: the
    // core hands a result over and returns to idle, so it can take the next
    // request while this result still waits for its transfer.
    logic      out_valid_reg;
    ffac_res_t out_res_reg;

    assign core_res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_res_valid && core_res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res_valid && core_res_ready)
        begin
            out_res_reg <= core_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign block_number = out_res_reg.block_number;

endmodule

// ===== hdl/ffac_checker.sv =====
// ----------------------------------------------------------------------------
// ffac_checker
// Port-level checks of the allocator, bound to its top level.
// ----------------------------------------------------------------------------
module ffac_checker
    import ffac_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [1:0]                status,
    input logic [BLOCK_W-1:0]        block_number
);

    // A result waiting for its transfer stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before its transfer");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_ALLOCATED) || (status == STAT_NO_SPACE)
                      || (status == STAT_ILLEGAL))
        else $error("undefined status code");

    // Failed requests carry block number zero.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_ALLOCATED) |-> (block_number == '0))
        else $error("nonzero block number on a failed request");

    // The core leaves idle at every request transfer, so the cycle after a
    // request transfer never accepts another.
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted in the cycle after a transfer");

endmodule

bind first_fit_allocator_with_compaction_unit ffac_checker u_ffac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .block_number (block_number)
);

// ===== dv/ffac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffac_scoreboard
// Watches the request, result and configuration ports of the first-fit
// allocator, keeps its own copy of the byte map and block numbers, and
// compares every result transfer with the predicted outcome.
// ----------------------------------------------------------------------------
module ffac_scoreboard
    import ffac_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    parameter int ID_LIMIT  = ID_LIMIT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [CFG_W-1:0]          cfg_write_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [ACTION_W-1:0]       action,
    input  logic [REQ_W-1:0]          request_size,
    input  logic signed [ERASE_W-1:0] erase_id,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [1:0]                status,
    input  logic [BLOCK_W-1:0]        block_number,
    output int                        fail_count,
    output int                        results_pending
);

    logic [7:0] byte_owner [MEM_BYTES];
    bit         id_live [ID_LIMIT];
    int         last_number;
    int         mem_size;
    int         mismatches;
    ffac_res_t  outcome_q [$];

    // Applies one request to the local map; returns 1 when it yields a result.
    function automatic bit apply_request(input action_t act, input logic [REQ_W-1:0] rsize,
                                         input logic signed [ERASE_W-1:0] eid,
                                         output ffac_res_t res);
        int span;
        int run;
        int base;
        int k;
        int w;
        int num;
        bit fit;
        res.status       = STAT_ALLOCATED;
        res.block_number = '0;
        if (act == ACT_ALLOC)
        begin
            span = (mem_size > MEM_BYTES) ? MEM_BYTES : mem_size;
            if (last_number >= ID_LIMIT - 1)
            begin
                res.status = STAT_NO_SPACE;
                return 1'b1;
            end
            fit  = (rsize == 0);
            run  = 0;
            base = 0;
            for (k = 0; k < span && !fit; k++)
            begin
                if (byte_owner[k] == 0)
                begin
                    run++;
                    if (run == rsize)
                    begin
                        base = k + 1 - int'(rsize);
                        fit  = 1'b1;
                    end
                end
                else
                begin
                    run = 0;
                end
            end
            if (!fit)
            begin
                res.status = STAT_NO_SPACE;
                return 1'b1;
            end
            last_number++;
            for (k = 0; k < rsize; k++)
                byte_owner[base + k] = last_number[7:0];
            id_live[last_number] = 1'b1;
            res.block_number     = last_number[BLOCK_W-1:0];
            return 1'b1;
        end
        else if (act == ACT_ERASE)
        begin
            num = int'(eid);
            if (num <= 0 || num >= ID_LIMIT || !id_live[num])
            begin
                res.status = STAT_ILLEGAL;
                return 1'b1;
            end
            id_live[num] = 1'b0;
            for (k = 0; k < MEM_BYTES; k++)
                if (byte_owner[k] == num)
                    byte_owner[k] = '0;
            return 1'b0;
        end
        // Every other code compacts the whole map, keeping the byte order.
        w = 0;
        for (k = 0; k < MEM_BYTES; k++)
        begin
            if (byte_owner[k] != 0)
            begin
                byte_owner[w] = byte_owner[k];
                w++;
            end
        end
        for (; w < MEM_BYTES; w++)
            byte_owner[w] = '0;
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ffac_res_t want;
        ffac_res_t got;
        if (!rst_n)
        begin
            foreach (byte_owner[k])
                byte_owner[k] = '0;
            foreach (id_live[k])
                id_live[k] = 1'b0;
            last_number = 0;
            mem_size    = int'(MEM_SIZE_RESET);
            mismatches  = 0;
            outcome_q.delete();
            fail_count      <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result transfer with nothing outstanding: status %0d block_number %0d",
                           status, block_number);
                    mismatches++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                    if (block_number !== want.block_number)
                    begin
                        $error("block_number: expected %0d, got %0d",
                               want.block_number, block_number);
                        mismatches++;
                    end
                end
            end
            if (cfg_write_en)
                mem_size = int'(cfg_write_data);
            if (in_valid && in_ready)
            begin
                if (apply_request(action_t'(action), request_size, erase_id, got))
                    outcome_q.insert(outcome_q.size(), got);
            end
            fail_count      <= mismatches;
            results_pending <= outcome_q.size();
        end
    end

endmodule

// ===== dv/first_fit_allocator_with_compaction_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_allocator_with_compaction_unit_tb
// Drives alloc, erase and compaction requests into the allocator through
// several memory sizes, with bursty request traffic and a stalling result
// receiver; the scoreboard beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module first_fit_allocator_with_compaction_unit_tb;
    import ffac_pkg::*;

    // The fourth request code has no name in the package; the block compacts on it.
    localparam action_t ACT_SPARE = 2'd3;

    // Longest request is a compaction, which reads the whole map and then fills its tail; allow some margin.
    localparam int SETTLE_CYCLES   = 2 * MEM_BYTES_DEF + 40;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 196;

    logic                      clk;
    logic                      rst_n          = 1'b0;
    logic                      cfg_write_en   = 1'b0;
    logic [CFG_W-1:0]          cfg_write_data = '0;
    logic                      in_valid       = 1'b0;
    logic                      in_ready;
    logic [ACTION_W-1:0]       action         = '0;
    logic [REQ_W-1:0]          request_size   = '0;
    logic signed [ERASE_W-1:0] erase_id       = '0;
    logic                      out_valid;
    logic                      out_ready      = 1'b0;
    logic [1:0]                status;
    logic [BLOCK_W-1:0]        block_number;

    int fail_count;
    int results_pending;

    // Remaining requests in the current burst of back-to-back transfers.
    int burst_left = 0;
    // Upper bound on block numbers handed out so far; steers erases toward live blocks.
    int numbers_bound = 0;
    // Receiver pattern: ready while ready_run counts down, then stalled while ready_hold counts down.
    int ready_run  = 0;
    int ready_hold = 0;

    first_fit_allocator_with_compaction_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .request_size   (request_size),
        .erase_id       (erase_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .block_number   (block_number)
    );

    ffac_scoreboard u_scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .request_size    (request_size),
        .erase_id        (erase_id),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .block_number    (block_number),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver stalls on its own schedule. About a quarter of the refills carry
    // no stall at all, which gives long stretches where results drain at once.
    always @(posedge clk)
    begin
        if (ready_run == 0 && ready_hold == 0)
        begin
            ready_run  = $urandom_range(1, 40);
            ready_hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
        if (ready_run > 0)
        begin
            ready_run--;
            out_ready <= 1'b1;
        end
        else
        begin
            ready_hold--;
            out_ready <= 1'b0;
        end
    end

    // Presents one request and holds it until the transfer happens. Requests go out
    // in bursts; at the end of a burst the channel idles for a random gap. Short gaps
    // vanish behind the block's scan, long ones reach into every phase of its work.
    task automatic send_request(input action_t a, input logic [REQ_W-1:0] sz,
                                input logic signed [ERASE_W-1:0] id);
        int gap_kind;
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 8);
        action       <= a;
        request_size <= sz;
        erase_id     <= id;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (a == ACT_ALLOC)
            numbers_bound++;
        burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap_kind = $urandom_range(0, 9);
            if (gap_kind < 5)
                repeat ($urandom_range(1, 4)) @(posedge clk);
            else if (gap_kind < 9)
                repeat ($urandom_range(5, 150)) @(posedge clk);
            else
                repeat ($urandom_range(150, 300)) @(posedge clk);
        end
    endtask

    // Stops the sender until every expected result has been taken, then lets the
    // block finish any erase or compaction that produces no result.
    task automatic drain_block();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mem_size(input logic [CFG_W-1:0] value);
        cfg_write_data <= value;
        cfg_write_en   <= 1'b1;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        int                        phase;
        int                        n;
        int                        roll;
        int                        size_roll;
        int                        lo;
        int                        hi;
        logic [CFG_W-1:0]          cfg_value;
        logic [REQ_W-1:0]          sz;
        logic signed [ERASE_W-1:0] id;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // The write lands during the clearing pass, which the block allows.
        write_mem_size(8'd128);

        // Directed opening. A zero-byte alloc takes number 1 and owns nothing, yet
        // it can be erased once; the second erase of it is illegal.
        send_request(ACT_ALLOC, 8'd0, 16'sd0);
        send_request(ACT_ERASE, 8'd0, 16'sd1);
        send_request(ACT_ERASE, 8'd0, 16'sd1);
        // Numbers that are zero, negative or beyond the number space are illegal.
        send_request(ACT_ERASE, 8'd0, 16'sd0);
        send_request(ACT_ERASE, 8'd0, -16'sd1);
        send_request(ACT_ERASE, 8'd0, -16'sd32768);
        send_request(ACT_ERASE, 8'd0, 16'sd32767);
        send_request(ACT_ERASE, 8'd0, 16'sd256);
        // Fill the whole map, then ask for more than is left and more than exists.
        send_request(ACT_ALLOC, 8'd128, 16'sd0);
        send_request(ACT_ALLOC, 8'd1, 16'sd0);
        send_request(ACT_ALLOC, 8'd255, -16'sd1);
        send_request(ACT_ERASE, 8'd255, 16'sd2);
        // Build a hole of three bytes and check that first fit skips it for a
        // larger request and uses it for a smaller one.
        send_request(ACT_ALLOC, 8'd5, 16'sd0);
        send_request(ACT_ALLOC, 8'd3, 16'sd0);
        send_request(ACT_ALLOC, 8'd7, 16'sd0);
        send_request(ACT_ERASE, 8'd0, 16'sd4);
        send_request(ACT_ALLOC, 8'd4, 16'sd0);
        send_request(ACT_ALLOC, 8'd2, 16'sd0);
        send_request(ACT_DEFRAG, 8'd0, 16'sd0);
        send_request(ACT_ALLOC, 8'd1, 16'sd0);
        send_request(ACT_ERASE, 8'd0, 16'sd3);
        // The spare code compacts like a defragment.
        send_request(ACT_SPARE, 8'hAA, 16'sh5555);
        send_request(ACT_ERASE, 8'd0, 16'sd255);
        send_request(ACT_ALLOC, 8'd120, 16'sd0);
        drain_block();

        // Random phases, each under its own memory size. Sizes above 128 act as 128,
        // zero leaves nothing to allocate. Between phases the sender waits for every
        // result, so each register write happens with the block idle.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       cfg_value = 8'd1;
                1:       cfg_value = 8'd200;
                2:       cfg_value = 8'd37;
                3:       cfg_value = 8'd0;
                4:       cfg_value = 8'd255;
                5:       cfg_value = CFG_W'($urandom_range(1, 128));
                6:       cfg_value = 8'd64;
                default: cfg_value = 8'd128;
            endcase
            write_mem_size(cfg_value);

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                sz   = REQ_W'($urandom);
                id   = ERASE_W'($urandom);
                if (roll < 32)
                begin
                    // Mostly small requests so the map fragments; a few exceed it.
                    size_roll = $urandom_range(0, 99);
                    if (size_roll < 8)
                        sz = 8'd0;
                    else if (size_roll < 70)
                        sz = REQ_W'($urandom_range(1, 12));
                    else if (size_roll < 92)
                        sz = REQ_W'($urandom_range(13, 64));
                    else if (size_roll < 97)
                        sz = REQ_W'($urandom_range(65, 128));
                    else
                        sz = REQ_W'($urandom_range(129, 255));
                    send_request(ACT_ALLOC, sz, id);
                end
                else if (roll < 72)
                begin
                    // Aim at recently handed-out numbers, most of which are live.
                    hi = (numbers_bound > 255) ? 255 : numbers_bound;
                    if (hi < 1)
                        hi = 1;
                    lo = (hi > 40) ? hi - 40 : 1;
                    id = ERASE_W'($urandom_range(lo, hi));
                    send_request(ACT_ERASE, sz, id);
                end
                else if (roll < 80)
                begin
                    send_request(ACT_ERASE, sz, id);
                end
                else if (roll < 94)
                begin
                    send_request(ACT_DEFRAG, sz, id);
                end
                else
                begin
                    send_request(ACT_SPARE, sz, id);
                end
            end
            drain_block();
        end

        if (fail_count == 0 && results_pending == 0)
            $display("first_fit_allocator_with_compaction_unit: match");
        else
            $display("first_fit_allocator_with_compaction_unit: mismatch");
        $finish;
    end

    // A correct run needs well under five million nanoseconds; this is a few times that.
    initial
    begin
        #(20_000_000);
        $display("first_fit_allocator_with_compaction_unit: mismatch");
        $finish;
    end

endmodule
